// ===== rtl/rlvad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlvad_pkg
// Widths, register indexes, reset values and the result type shared by the
// rms level voice activity detector and its serial arithmetic units.
// ----------------------------------------------------------------------------
package rlvad_pkg;

	// field and state widths
	localparam int SAMPLE_W   = 16;
	localparam int SQ_W       = 2 * SAMPLE_W - 1;
	localparam int ENERGY_W   = 42;
	localparam int MAX_BUFFER = 4096;
	localparam int COUNT_W    = $clog2(MAX_BUFFER + 1);
	localparam int DIVIDEND_W = ENERGY_W + 4;
	localparam int ROOT_W     = DIVIDEND_W / 2;
	localparam int LEVEL_W    = 16;
	localparam int ALPHA_W    = 16;
	localparam int THRESH_W   = 16;
	localparam int HANG_W     = 16;
	localparam int PERIOD_W   = 10;
	localparam int INTERVAL_W = 8;
	localparam int MS_W       = 16;

	localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ALPHA      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE_THRESH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HANGOVER_MS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD_MS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL  = 3'd4;

	localparam logic [ALPHA_W-1:0]    RST_LEVEL_ALPHA      = 16'd19661;
	localparam logic [THRESH_W-1:0]   RST_VOICE_THRESH     = 16'd655;
	localparam logic [HANG_W-1:0]     RST_HANGOVER_MS      = 16'd500;
	localparam logic [PERIOD_W-1:0]   RST_UPDATE_PERIOD_MS = 10'd50;
	localparam logic [INTERVAL_W-1:0] RST_REPORT_INTERVAL  = 8'd10;

	// request kinds
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef struct packed {
		logic                       pcm_valid;
		logic signed [SAMPLE_W-1:0] pcm_out;
		logic                       level_valid;
		logic [LEVEL_W-1:0]         level_out;
		logic                       level_report;
		logic                       voice_active;
		logic                       voice_changed;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/rlvad_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlvad_if
// Valid/ready channels of the detector: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface rlvad_item_if;
	import rlvad_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       last_of_buffer;

	modport source (output valid, output req_type, output sample_value,
		output last_of_buffer, input ready);
	modport sink (input valid, input req_type, input sample_value,
		input last_of_buffer, output ready);
endinterface

interface rlvad_result_if;
	import rlvad_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       pcm_valid;
	logic signed [SAMPLE_W-1:0] pcm_out;
	logic                       level_valid;
	logic [LEVEL_W-1:0]         level_out;
	logic                       level_report;
	logic                       voice_active;
	logic                       voice_changed;

	modport source (output valid, output pcm_valid, output pcm_out,
		output level_valid, output level_out, output level_report,
		output voice_active, output voice_changed, input ready);
	modport sink (input valid, input pcm_valid, input pcm_out,
		input level_valid, input level_out, input level_report,
		input voice_active, input voice_changed, output ready);
endinterface

interface rlvad_cfg_if;
	import rlvad_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rlvad_sqr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlvad_sqr
// Bit-serial squarer: one multiplier bit per cycle, shift-and-add.
// ----------------------------------------------------------------------------
module rlvad_sqr (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rlvad_pkg::SAMPLE_W-1:0] mag,
	output logic                               done,
	output logic [rlvad_pkg::SQ_W-1:0]         square
);
	import rlvad_pkg::*;

	localparam int STEPS = SAMPLE_W;
	localparam int CNT_W = $clog2(STEPS);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SQ_W-1:0]     mcand_q;
	logic [SAMPLE_W-1:0] mplier_q;
	logic [SQ_W-1:0]     acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			acc_q    <= '0;
		end else if (start) begin
			busy_q   <= 1'b1;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			mcand_q  <= SQ_W'(mag);
			mplier_q <= mag;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			cnt_q    <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done   = done_q;
	assign square = acc_q;

endmodule
`default_nettype wire

// ===== rtl/rlvad_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlvad_div
// Restoring divider, one quotient bit per cycle. The dividend register
// shifts out at the top while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module rlvad_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [rlvad_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [rlvad_pkg::COUNT_W-1:0]    divisor,
	output logic                                 done,
	output logic [rlvad_pkg::DIVIDEND_W-1:0]     quotient
);
	import rlvad_pkg::*;

	localparam int STEPS = DIVIDEND_W;
	localparam int CNT_W = $clog2(STEPS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [COUNT_W-1:0]    rem_q;
	logic [COUNT_W-1:0]    divisor_q;

	logic [COUNT_W:0] shifted;
	logic [COUNT_W:0] diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, dq_q[DIVIDEND_W-1]};
		diff    = shifted - {1'b0, divisor_q};
		ge      = shifted >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			dq_q      <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
		end else if (start) begin
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			dq_q      <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule
`default_nettype wire

// ===== rtl/rlvad_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlvad_sqrt
// Digit-by-digit integer square root: two radicand bits per cycle, one
// root bit per cycle, result is the floor of the square root.
// ----------------------------------------------------------------------------
module rlvad_sqrt (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [rlvad_pkg::DIVIDEND_W-1:0] radicand,
	output logic                                 done,
	output logic [rlvad_pkg::ROOT_W-1:0]         root
);
	import rlvad_pkg::*;

	localparam int STEPS = ROOT_W;
	localparam int CNT_W = $clog2(STEPS);
	localparam int REM_W = ROOT_W + 2;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] x_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;

	logic [REM_W+1:0] shifted;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, x_q[DIVIDEND_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		diff    = shifted - trial;
		ge      = shifted >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			// remainder stays below twice the root plus one
			rem_q  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			x_q    <= {x_q[DIVIDEND_W-3:0], 2'b00};
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== rtl/rlvad_smooth.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rlvad_smooth
// Exponential smoothing step old*(1-alpha) + level*alpha, formed bit-serially
// over the alpha bits and floored to Q1.15.
// ----------------------------------------------------------------------------
module rlvad_smooth (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rlvad_pkg::LEVEL_W-1:0] old_level,
	input  wire logic [rlvad_pkg::LEVEL_W-1:0] new_level,
	input  wire logic [rlvad_pkg::ALPHA_W-1:0] alpha,
	output logic                              done,
	output logic [rlvad_pkg::LEVEL_W-1:0]     level
);
	import rlvad_pkg::*;

	localparam int STEPS = ALPHA_W + 1;
	localparam int CNT_W = $clog2(STEPS);
	localparam int ACC_W = LEVEL_W + ALPHA_W;

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ALPHA_W:0]   alpha_q;
	logic [ALPHA_W:0]   beta_q;
	logic [ACC_W-1:0]   old_q;
	logic [ACC_W-1:0]   new_q;
	logic [ACC_W-1:0]   acc_q;

	logic [ALPHA_W:0] beta;
	logic [ACC_W-1:0] part_old;
	logic [ACC_W-1:0] part_new;

	always_comb begin
		beta     = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, alpha};
		part_old = beta_q[0] ? old_q : '0;
		part_new = alpha_q[0] ? new_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			alpha_q <= '0;
			beta_q  <= '0;
			old_q   <= '0;
			new_q   <= '0;
			acc_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			alpha_q <= {1'b0, alpha};
			beta_q  <= beta;
			old_q   <= ACC_W'(old_level);
			new_q   <= ACC_W'(new_level);
			acc_q   <= '0;
		end else if (busy_q) begin
			// partial sums never pass the final total, at most one in Q1.31
			acc_q   <= acc_q + part_old + part_new;
			old_q   <= old_q << 1;
			new_q   <= new_q << 1;
			alpha_q <= alpha_q >> 1;
			beta_q  <= beta_q >> 1;
			cnt_q   <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done  = done_q;
	assign level = acc_q[ACC_W-1:ALPHA_W];

endmodule
`default_nettype wire

// ===== rtl/rms_level_voice_activity_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rms_level_voice_activity_detector
// Energy voice activity detector with hangover for Q1.15 mono audio. Every
// accepted transaction gives exactly one result. An audio sample returns its
// PCM value one step toward zero and adds its square to the buffer energy; a
// sample that ends a buffer (last_of_buffer, or the MAX_BUFFER-th sample)
// also updates the smoothed level min(1.0, 3*rms) and may raise the periodic
// report flag. A tick updates the voice decision against the voice threshold
// and the hangover time. One item is worked at a time: a tick is decided in
// the tick state, a sample waits on the 16-step serial squarer, and a buffer
// end also on the 46-step serial divider, the 23-step square root and the
// 17-step smoothing multiply in series. The result register lets the next
// transaction be accepted while a result still waits to be taken.
// Configuration writes are taken in any cycle and act as soon as written.
// ----------------------------------------------------------------------------
module rms_level_voice_activity_detector (
	input  wire logic      clk,
	input  wire logic      arst_n,
	rlvad_item_if.sink     item,
	rlvad_result_if.source result,
	rlvad_cfg_if.sink      cfg
);
	import rlvad_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SQR    = 3'd1;
	localparam logic [2:0] S_ACC    = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_SQRT   = 3'd4;
	localparam logic [2:0] S_SMOOTH = 3'd5;
	localparam logic [2:0] S_TICK   = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0] state_q;

	// configuration
	logic [ALPHA_W-1:0]    alpha_q;
	logic [THRESH_W-1:0]   thresh_q;
	logic [HANG_W-1:0]     hang_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [INTERVAL_W-1:0] interval_q;

	// detector state
	logic [ENERGY_W-1:0]   energy_q;
	logic [COUNT_W-1:0]    count_q;
	logic [LEVEL_W-1:0]    smoothed_q;
	logic [INTERVAL_W-1:0] since_report_q;
	logic                  flag_q;
	logic [MS_W-1:0]       ms_q;

	logic    last_q;
	logic    end_q;
	result_t res_q;
	result_t out_q;
	logic    out_vld_q;
	logic    out_load;

	// serial units
	logic                  sqr_start;
	logic                  sqr_done;
	logic [SQ_W-1:0]       sqr_value;
	logic                  div_start;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] dividend;
	logic [DIVIDEND_W-1:0] quotient;
	logic                  sqrt_start;
	logic                  sqrt_done;
	logic [ROOT_W-1:0]     root;
	logic                  smooth_start;
	logic                  smooth_done;
	logic [LEVEL_W-1:0]    smooth_level;
	logic [LEVEL_W-1:0]    level_clamped;

	logic                       item_take;
	logic signed [SAMPLE_W-1:0] s_in;
	logic signed [SAMPLE_W-1:0] pcm_conv;
	logic [SAMPLE_W-1:0]        sample_mag;
	logic [ENERGY_W:0]          energy_sum;
	logic [ENERGY_W-1:0]        energy_sat;
	logic [COUNT_W-1:0]         count_inc;
	logic [INTERVAL_W-1:0]      since_inc;
	logic                       report_now;
	logic [MS_W:0]              ms_sum;
	logic [MS_W-1:0]            ms_sat;
	result_t                    res_final;

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_take  = item.valid && item.ready;
	assign out_load   = (state_q == S_OUT) && (!out_vld_q || result.ready);

	always_comb begin
		s_in = item.sample_value;
		if (s_in > 0) begin
			pcm_conv = s_in - 16'sd1;
		end else if (s_in < 0) begin
			pcm_conv = s_in + 16'sd1;
		end else begin
			pcm_conv = '0;
		end
		sample_mag = s_in[SAMPLE_W-1] ? (~$unsigned(s_in) + 1'b1) : $unsigned(s_in);

		energy_sum = {1'b0, energy_q} + (ENERGY_W + 1)'(sqr_value);
		energy_sat = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
		count_inc  = count_q + 1'b1;

		// nine times the energy, as 8x + x
		dividend = DIVIDEND_W'({energy_q, 3'b000}) + DIVIDEND_W'(energy_q);

		level_clamped = (root > ROOT_W'(LEVEL_ONE)) ? LEVEL_ONE : root[LEVEL_W-1:0];

		since_inc  = since_report_q + 1'b1;
		report_now = since_inc >= interval_q;

		ms_sum = {1'b0, ms_q} + (MS_W + 1)'(period_q);
		ms_sat = ms_sum[MS_W] ? '1 : ms_sum[MS_W-1:0];

		res_final              = res_q;
		res_final.level_out    = smoothed_q;
		res_final.voice_active = flag_q;
	end

	assign sqr_start    = item_take && (item.req_type == REQ_SAMPLE);
	assign div_start    = (state_q == S_ACC) && end_q;
	assign sqrt_start   = (state_q == S_DIV) && div_done;
	assign smooth_start = (state_q == S_SQRT) && sqrt_done;

	rlvad_sqr u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqr_start),
		.mag    (sample_mag),
		.done   (sqr_done),
		.square (sqr_value)
	);

	rlvad_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	rlvad_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (quotient),
		.done     (sqrt_done),
		.root     (root)
	);

	rlvad_smooth u_smooth (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (smooth_start),
		.old_level (smoothed_q),
		.new_level (level_clamped),
		.alpha     (alpha_q),
		.done      (smooth_done),
		.level     (smooth_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			alpha_q        <= RST_LEVEL_ALPHA;
			thresh_q       <= RST_VOICE_THRESH;
			hang_q         <= RST_HANGOVER_MS;
			period_q       <= RST_UPDATE_PERIOD_MS;
			interval_q     <= RST_REPORT_INTERVAL;
			energy_q       <= '0;
			count_q        <= '0;
			smoothed_q     <= '0;
			since_report_q <= '0;
			flag_q         <= 1'b0;
			ms_q           <= '0;
			last_q         <= 1'b0;
			end_q          <= 1'b0;
			res_q          <= '0;
			out_q          <= '0;
			out_vld_q      <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_LEVEL_ALPHA:      alpha_q    <= cfg.data[ALPHA_W-1:0];
					REG_VOICE_THRESH:     thresh_q   <= cfg.data[THRESH_W-1:0];
					REG_HANGOVER_MS:      hang_q     <= cfg.data[HANG_W-1:0];
					REG_UPDATE_PERIOD_MS: period_q   <= cfg.data[PERIOD_W-1:0];
					REG_REPORT_INTERVAL:  interval_q <= cfg.data[INTERVAL_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (item_take) begin
						res_q <= '0;
						if (item.req_type == REQ_TICK) begin
							state_q <= S_TICK;
						end else begin
							res_q.pcm_valid <= 1'b1;
							res_q.pcm_out   <= pcm_conv;
							last_q          <= item.last_of_buffer;
							state_q         <= S_SQR;
						end
					end
				end
				S_SQR: begin
					if (sqr_done) begin
						energy_q <= energy_sat;
						count_q  <= count_inc;
						end_q    <= last_q || (count_inc == COUNT_W'(MAX_BUFFER));
						state_q  <= S_ACC;
					end
				end
				S_ACC: begin
					if (end_q) begin
						// divider has latched its operands on this edge
						energy_q <= '0;
						count_q  <= '0;
						state_q  <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_SMOOTH;
					end
				end
				S_SMOOTH: begin
					if (smooth_done) begin
						smoothed_q         <= smooth_level;
						since_report_q     <= report_now ? '0 : since_inc;
						res_q.level_valid  <= 1'b1;
						res_q.level_report <= report_now;
						state_q            <= S_OUT;
					end
				end
				S_TICK: begin
					if (smoothed_q > thresh_q) begin
						ms_q <= '0;
						if (!flag_q) begin
							flag_q              <= 1'b1;
							res_q.voice_changed <= 1'b1;
						end
					end else begin
						ms_q <= ms_sat;
						if (flag_q && (ms_sat > hang_q)) begin
							flag_q              <= 1'b0;
							res_q.voice_changed <= 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_q   <= res_final;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid         = out_vld_q;
	assign result.pcm_valid     = out_q.pcm_valid;
	assign result.pcm_out       = out_q.pcm_out;
	assign result.level_valid   = out_q.level_valid;
	assign result.level_out     = out_q.level_out;
	assign result.level_report  = out_q.level_report;
	assign result.voice_active  = out_q.voice_active;
	assign result.voice_changed = out_q.voice_changed;

`ifndef SYNTH
	a_report_needs_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (!out_q.level_report || out_q.level_valid))
		else $error("level report without level update");

	a_tick_or_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_q.pcm_valid && out_q.voice_changed))
		else $error("voice change reported on an audio sample");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		smoothed_q <= LEVEL_ONE)
		else $error("smoothed level above one");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (count_q < COUNT_W'(MAX_BUFFER)))
		else $error("buffer count reached limit without ending the buffer");

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> (state_q != S_IDLE))
		else $error("accepted transaction not processed");
`endif

endmodule
`default_nettype wire
